>>> design/rfae_pkg.sv
// package: opcodes, states, command and status types for the register file alu executor
package rfae_pkg;

  localparam int unsigned DATA_W = 64;

  localparam logic [7:0] OP_ADD    = 8'h10;
  localparam logic [7:0] OP_SUB    = 8'h11;
  localparam logic [7:0] OP_MUL    = 8'h12;
  localparam logic [7:0] OP_DIV    = 8'h13;
  localparam logic [7:0] OP_INC    = 8'h14;
  localparam logic [7:0] OP_DEC    = 8'h15;
  localparam logic [7:0] OP_CMP3U  = 8'h16;
  localparam logic [7:0] OP_LTU    = 8'h17;
  localparam logic [7:0] OP_GTU    = 8'h18;
  localparam logic [7:0] OP_NOT    = 8'h19;
  localparam logic [7:0] OP_AND    = 8'h1a;
  localparam logic [7:0] OP_OR     = 8'h1b;
  localparam logic [7:0] OP_XOR    = 8'h1c;
  localparam logic [7:0] OP_BOOL   = 8'h1d;
  localparam logic [7:0] OP_MOV8   = 8'h20;
  localparam logic [7:0] OP_MOV16  = 8'h21;
  localparam logic [7:0] OP_MOV32  = 8'h22;
  localparam logic [7:0] OP_MOV64  = 8'h23;
  localparam logic [7:0] OP_SWAP   = 8'h57;
  localparam logic [7:0] OP_FBCD   = 8'h60;
  localparam logic [7:0] OP_TBCD   = 8'h61;
  localparam logic [7:0] OP_SGNTO  = 8'h62;
  localparam logic [7:0] OP_SGNFR  = 8'h63;
  localparam logic [7:0] OP_SHL    = 8'h64;
  localparam logic [7:0] OP_SHR    = 8'h65;
  localparam logic [7:0] OP_ROL    = 8'h66;
  localparam logic [7:0] OP_ROR    = 8'h67;
  localparam logic [7:0] OP_CPL    = 8'h68;
  localparam logic [7:0] OP_IMUL   = 8'h69;
  localparam logic [7:0] OP_IDIV   = 8'h6a;
  localparam logic [7:0] OP_CMP3S  = 8'h6b;
  localparam logic [7:0] OP_LTS    = 8'h6c;
  localparam logic [7:0] OP_GTS    = 8'h6d;
  localparam logic [7:0] OP_SAL    = 8'h6e;
  localparam logic [7:0] OP_SAR    = 8'h6f;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  typedef enum logic [1:0] {
    K_SIMPLE, K_MUL, K_DIV, K_TBCD
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_ITER, S_FIX, S_WR1, S_WR2, S_OUT
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic rd_sel;
    logic cap1;
    logic cap2;
    logic start;
    logic step;
    logic fix;
    logic wr1;
    logic wr2;
  } cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic       valid_op;
    logic       div0;
    logic       two_dst;
    logic       iter_last;
  } sts_t;

endpackage

>>> design/rfae_if.sv
// valid/ready channel interface carrying one payload
interface rfae_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/rfae_ram.sv
// generic single write port, single read port ram with registered read
module rfae_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/rfae_ctrl.sv
// controller state machine sequencing clear, reads, execution and writes
module rfae_ctrl
  import rfae_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd,
  output logic [$clog2(REGISTER_COUNT)-1:0] clr_addr
);
  localparam int unsigned AW = $clog2(REGISTER_COUNT);

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  assign clr_addr = clr_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == AW'(REGISTER_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_EXEC;
      S_EXEC: begin
        priority if (!sts.valid_op || sts.div0) state_nxt = S_OUT;
        else if (sts.kind == K_SIMPLE) state_nxt = S_WR1;
        else state_nxt = S_ITER;
      end
      S_ITER:  if (sts.iter_last) state_nxt = S_FIX;
      S_FIX:   state_nxt = S_WR1;
      S_WR1:   state_nxt = sts.two_dst ? S_WR2 : S_OUT;
      S_WR2:   state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clr_wr = 1'b1;
      S_IDLE:  in_ready = 1'b1;
      S_RD1:   begin cmd.rd_sel = 1'b1; cmd.cap1 = 1'b1; end
      S_RD2:   cmd.cap2 = 1'b1;
      S_EXEC:  cmd.start = 1'b1;
      S_ITER:  cmd.step = 1'b1;
      S_FIX:   cmd.fix = 1'b1;
      S_WR1:   cmd.wr1 = 1'b1;
      S_WR2:   cmd.wr2 = 1'b1;
      S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

>>> design/rfae_dp.sv
// datapath: register file, operand registers, alu, multiply, divide and bcd units
module rfae_dp
  import rfae_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = 256
) (
  input  logic        clk,
  input  logic        in_xfer,
  input  logic [7:0]  in_op,
  input  logic [7:0]  in_reg_a,
  input  logic [7:0]  in_reg_b,
  input  logic [7:0]  in_reg_c,
  input  logic [7:0]  in_reg_d,
  input  cmd_t        cmd,
  input  logic [$clog2(REGISTER_COUNT)-1:0] clr_addr,
  output sts_t        sts,
  output logic [1:0]  out_status,
  output logic [63:0] out_first_value,
  output logic [63:0] out_second_value
);
  localparam int unsigned AW = $clog2(REGISTER_COUNT);

  logic [7:0]    op_r;
  logic [AW-1:0] a_r, b_r, c_r, d_r;
  logic [63:0]   ra_r, rb_r, rc_r, rd_r;
  logic [63:0]   v1_r, v2_r;
  logic [1:0]    st_r;
  logic [6:0]    cnt_r;
  logic          neg_q_r, neg_r_r;
  logic [63:0]   acc_r, opx_r, opy_r;

  // two read ports via two ram copies written identically
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic [AW-1:0] raddr0, raddr1;
  logic [63:0]   rdata0, rdata1;

  always_comb begin
    priority if (cmd.clr_wr) begin
      we = 1'b1; waddr = clr_addr; wdata = '0;
    end else if (cmd.wr1) begin
      we = 1'b1; waddr = (op_r == OP_SGNTO) ? b_r : a_r; wdata = v1_r;
    end else if (cmd.wr2) begin
      we = 1'b1; waddr = (op_r == OP_SGNTO) ? c_r : b_r; wdata = v2_r;
    end else begin
      we = 1'b0; waddr = a_r; wdata = v1_r;
    end
  end

  // b and a are read in the transfer cycle, c and d in the cycle after
  assign raddr0 = cmd.rd_sel ? c_r : (in_xfer ? AW'(in_reg_b) : b_r);
  assign raddr1 = cmd.rd_sel ? d_r : (in_xfer ? AW'(in_reg_a) : a_r);

  rfae_ram #(.WIDTH(64), .DEPTH(REGISTER_COUNT)) u_ram0 (
    .clk, .we, .waddr, .wdata, .raddr(raddr0), .rdata(rdata0)
  );
  rfae_ram #(.WIDTH(64), .DEPTH(REGISTER_COUNT)) u_ram1 (
    .clk, .we, .waddr, .wdata, .raddr(raddr1), .rdata(rdata1)
  );

  // opcode decode
  kind_t kind;
  logic  valid_op, two_dst;
  always_comb begin
    kind = K_SIMPLE; valid_op = 1'b1; two_dst = 1'b0;
    unique case (op_r)
      OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_CMP3U, OP_CMP3S, OP_LTU, OP_GTU, OP_LTS,
      OP_GTS, OP_NOT, OP_BOOL, OP_CPL, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SAL,
      OP_SHR, OP_SAR, OP_ROL, OP_ROR, OP_MOV8, OP_MOV16, OP_MOV32, OP_MOV64,
      OP_SGNFR: ;
      OP_FBCD: kind = K_MUL;
      OP_MUL, OP_IMUL: kind = K_MUL;
      OP_TBCD: kind = K_TBCD;
      OP_DIV, OP_IDIV: begin kind = K_DIV; two_dst = 1'b1; end
      OP_SWAP, OP_SGNTO: two_dst = 1'b1;
      default: valid_op = 1'b0;
    endcase
  end

  // simple alu on operands b,c,a
  logic [5:0]   s;
  logic [63:0]  alu;
  logic [127:0] rot;
  logic         ltu, gtu, lts, gts;
  assign s   = rc_r[5:0];
  assign ltu = rb_r < rc_r;
  assign gtu = rb_r > rc_r;
  assign lts = (rb_r ^ 64'h8000_0000_0000_0000) < (rc_r ^ 64'h8000_0000_0000_0000);
  assign gts = (rb_r ^ 64'h8000_0000_0000_0000) > (rc_r ^ 64'h8000_0000_0000_0000);
  assign rot = {rb_r, rb_r};

  always_comb begin
    alu = '0;
    unique case (op_r)
      OP_ADD:   alu = rb_r + rc_r;
      OP_SUB:   alu = rb_r - rc_r;
      OP_INC:   alu = ra_r + 64'd1;
      OP_DEC:   alu = ra_r - 64'd1;
      OP_CMP3U: alu = gtu ? 64'd1 : (ltu ? '1 : '0);
      OP_CMP3S: alu = gts ? 64'd1 : (lts ? '1 : '0);
      OP_LTU:   alu = {63'd0, ltu};
      OP_GTU:   alu = {63'd0, gtu};
      OP_LTS:   alu = {63'd0, lts};
      OP_GTS:   alu = {63'd0, gts};
      OP_NOT:   alu = {63'd0, rb_r == '0};
      OP_BOOL:  alu = {63'd0, rb_r != '0};
      OP_CPL:   alu = ~rb_r;
      OP_AND:   alu = rb_r & rc_r;
      OP_OR:    alu = rb_r | rc_r;
      OP_XOR:   alu = rb_r ^ rc_r;
      OP_SHL, OP_SAL: alu = rb_r << s;
      OP_SHR:   alu = rb_r >> s;
      OP_SAR:   alu = 64'($signed(rb_r) >>> s);
      OP_ROL:   alu = rot[7'd64 - {1'b0, s} +: 64];
      OP_ROR:   alu = rot[{1'b0, s} +: 64];
      OP_MOV8:  alu = {56'd0, rb_r[7:0]};
      OP_MOV16: alu = {48'd0, rb_r[15:0]};
      OP_MOV32: alu = {32'd0, rb_r[31:0]};
      OP_MOV64: alu = rb_r;
      OP_SGNFR: alu = (rc_r != '0) ? rb_r : (~rb_r + 64'd1);
      default:  alu = '0;
    endcase
  end

  // iterative units: mul is shift-add over 64 steps, bcd-from is 16 digit steps,
  // div is restoring 64 steps, bcd-to is 64 steps of double dabble
  logic [63:0] a_mag, d_mag;
  assign a_mag = rc_r[63] ? (~rc_r + 64'd1) : rc_r;
  assign d_mag = rd_r[63] ? (~rd_r + 64'd1) : rd_r;

  logic [64:0] rem_sh;
  assign rem_sh  = {opy_r, opx_r[63]};

  // add three to every low bcd digit above four before the shift
  logic [63:0] dd_adj;
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      dd_adj[4*k +: 4] = (opy_r[4*k +: 4] >= 4'd5) ? opy_r[4*k +: 4] + 4'd3
                                                    : opy_r[4*k +: 4];
    end
  end

  logic last;
  assign last = (op_r == OP_FBCD) ? (cnt_r == 7'd15) : (cnt_r == 7'd63);

  logic [63:0] pow10_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= in_op;
      a_r  <= AW'(in_reg_a);
      b_r  <= AW'(in_reg_b);
      c_r  <= AW'(in_reg_c);
      d_r  <= AW'(in_reg_d);
      st_r <= ST_DONE;
      v1_r <= '0;
      v2_r <= '0;
    end
    if (cmd.cap1) begin
      rb_r <= rdata0;
      ra_r <= rdata1;
    end
    if (cmd.cap2) begin
      rc_r <= rdata0;
      rd_r <= rdata1;
    end
    if (cmd.start) begin
      cnt_r <= '0;
      priority if (!valid_op) begin
        st_r <= ST_UNSUP;
      end else if (kind == K_DIV && rd_r == '0) begin
        st_r <= ST_DIV0;
      end else if (kind == K_SIMPLE) begin
        if (op_r == OP_SWAP) begin
          v1_r <= rb_r; v2_r <= ra_r;
        end else if (op_r == OP_SGNTO) begin
          v1_r <= ra_r[63] ? (~ra_r + 64'd1) : ra_r;
          v2_r <= {63'd0, ~ra_r[63]};
        end else begin
          v1_r <= alu;
        end
      end else if (kind == K_DIV) begin
        opx_r   <= (op_r == OP_IDIV) ? a_mag : rc_r;
        acc_r   <= (op_r == OP_IDIV) ? d_mag : rd_r;
        opy_r   <= '0;
        neg_q_r <= (op_r == OP_IDIV) && (rc_r[63] ^ rd_r[63]);
        neg_r_r <= (op_r == OP_IDIV) && rc_r[63];
      end else if (kind == K_TBCD) begin
        acc_r <= rb_r;
        opy_r <= '0;
      end else if (op_r == OP_FBCD) begin
        opx_r   <= rb_r;
        acc_r   <= '0;
        pow10_r <= 64'd1;
      end else begin
        opx_r <= rb_r;
        opy_r <= rc_r;
        acc_r <= '0;
      end
    end
    if (cmd.step) begin
      cnt_r <= cnt_r + 7'd1;
      unique case (kind)
        K_DIV: begin
          // opx: dividend shifting into quotient, opy: remainder, acc: divisor
          if (rem_sh >= {1'b0, acc_r}) begin
            opy_r <= rem_sh[63:0] - acc_r;
            opx_r <= {opx_r[62:0], 1'b1};
          end else begin
            opy_r <= rem_sh[63:0];
            opx_r <= {opx_r[62:0], 1'b0};
          end
        end
        K_TBCD: begin
          // acc: binary shifting out msb first, opy: low 16 bcd digits
          opy_r <= {dd_adj[62:0], acc_r[63]};
          acc_r <= {acc_r[62:0], 1'b0};
        end
        K_MUL: begin
          if (op_r == OP_FBCD) begin
            acc_r   <= acc_r + 64'({60'd0, opx_r[3:0]} * pow10_r);
            opx_r   <= opx_r >> 4;
            pow10_r <= 64'(pow10_r * 64'd10);
          end else begin
            if (opy_r[0]) acc_r <= acc_r + opx_r;
            opx_r <= opx_r << 1;
            opy_r <= opy_r >> 1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.fix) begin
      unique case (kind)
        K_DIV: begin
          v1_r <= neg_q_r ? (~opx_r + 64'd1) : opx_r;
          v2_r <= neg_r_r ? (~opy_r + 64'd1) : opy_r;
        end
        K_TBCD: v1_r <= opy_r;
        default: v1_r <= acc_r;
      endcase
    end
  end

  assign sts.kind      = kind;
  assign sts.valid_op  = valid_op;
  assign sts.div0      = (kind == K_DIV) && (rd_r == '0);
  assign sts.two_dst   = two_dst;
  assign sts.iter_last = last;

  assign out_status       = st_r;
  assign out_first_value  = v1_r;
  assign out_second_value = v2_r;
endmodule

>>> design/register_file_alu_executor_top.sv
// top level: register file alu executor
// channel | dir | payload
// in      | in  | op, reg_a, reg_b, reg_c, reg_d
// out     | out | status, first_value, second_value
// per instruction: read both operand pairs, execute, write, out; mul, div and bcd iterate and
// fix before the write; div, swap and sign-to write two, unsupported or divide by zero none
// mul, div and double dabble iterate 64 steps, the bcd-from digit loop 16 steps
// after reset a clearing pass zeroes every register of the file, no transfer taken
// one instruction at a time; the result holds in out until taken
module register_file_alu_executor_top
  import rfae_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT = 256
) (
  input  logic   clk,
  input  logic   rst_n,
  rfae_if.sink   in_ch,
  rfae_if.source out_ch
);
  localparam int unsigned AW = $clog2(REGISTER_COUNT);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] clr_addr;

  rfae_ctrl #(.REGISTER_COUNT(REGISTER_COUNT)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd, .clr_addr
  );

  rfae_dp #(.REGISTER_COUNT(REGISTER_COUNT)) u_dp (
    .clk,
    .in_xfer(in_ch.valid && in_ch.ready),
    .in_op(in_ch.data.op), .in_reg_a(in_ch.data.reg_a), .in_reg_b(in_ch.data.reg_b),
    .in_reg_c(in_ch.data.reg_c), .in_reg_d(in_ch.data.reg_d),
    .cmd, .clr_addr, .sts,
    .out_status(out_ch.data.status),
    .out_first_value(out_ch.data.first_value),
    .out_second_value(out_ch.data.second_value)
  );
endmodule

>>> design/rfae_chk.sv
// port checker for the executor, bound to the top level
module rfae_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while result pending");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second transfer");
endmodule

bind register_file_alu_executor_top rfae_chk u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.data.status)
);
